// ===== src/abkf_pkg.sv =====
// ----------------------------------------------------------------------------
// abkf_pkg
// Shared codes for the angle / gyro-bias Kalman filter core.
// ----------------------------------------------------------------------------
`default_nettype none
package abkf_pkg;
    // configuration register indexes
    localparam logic [1:0] REG_TIME_STEP     = 2'd0;
    localparam logic [1:0] REG_ANGLE_NOISE   = 2'd1;
    localparam logic [1:0] REG_BIAS_NOISE    = 2'd2;
    localparam logic [1:0] REG_MEASURE_NOISE = 2'd3;

    localparam int IO_WIDTH = 32;

    // operation codes of the shared unit
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } alu_op_t;
endpackage
`default_nettype wire

// ===== src/angle_bias_kalman_filter_core.sv =====
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter_core
// Two-state angle / gyro-bias Kalman filter on one shared arithmetic unit.
// ----------------------------------------------------------------------------
// Program: 30 micro-steps, two of them bit-serial divides.
// The input is not ready while an item is in flight, so a new item
// is taken only after the previous result has been accepted.
// Reset: asynchronous, clears state, covariance and sequencer; registers
// return to their defaults (dt 0.01, Q_angle 0.001, Q_bias 0.003, R 0.03).
`default_nettype none
module angle_bias_kalman_filter_core
    import abkf_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [31:0] measured_angle, [63:32] measured_rate
    input  wire logic [63:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [31:0] angle_estimate, [63:32] bias_estimate
    output logic      [63:0] m_axis_tdata
);
    localparam int W  = DATA_WIDTH;
    localparam int PW = 2 * DATA_WIDTH;
    localparam int DN = DATA_WIDTH + FRAC_BITS;
    localparam int CW = $clog2(DN + 1);
    localparam int EW = ((W > IO_WIDTH) ? W : IO_WIDTH) + 2;

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ISSUE = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    // register file slots
    localparam logic [3:0] R_DT = 4'd0, R_QA = 4'd1, R_QB = 4'd2, R_R = 4'd3;
    localparam logic [3:0] R_Z = 4'd4, R_RT = 4'd5, R_AN = 4'd6, R_BI = 4'd7;
    localparam logic [3:0] R_P00 = 4'd8, R_P01 = 4'd9, R_P10 = 4'd10;
    localparam logic [3:0] R_P11 = 4'd11, R_T = 4'd12, R_K0 = 4'd13;
    localparam logic [3:0] R_K1 = 4'd14, R_Y = 4'd15;
    localparam int NSTEP = 26;

    typedef struct packed {
        alu_op_t    op;
        logic [3:0] a;
        logic [3:0] b;
        logic [3:0] d;
    } uop_t;

    // micro-program: d = a op b
    function automatic uop_t prog(input logic [4:0] i);
        uop_t u;
        u = '{OP_ADD, R_Z, R_Z, R_Z};
        case (i)
            5'd0:  u = '{OP_SUB, R_RT, R_BI, R_RT};   // rate
            5'd1:  u = '{OP_MUL, R_DT, R_RT, R_RT};
            5'd2:  u = '{OP_ADD, R_AN, R_RT, R_AN};   // angle predict
            5'd3:  u = '{OP_MUL, R_DT, R_P11, R_T};
            5'd4:  u = '{OP_SUB, R_T, R_P01, R_T};
            5'd5:  u = '{OP_SUB, R_T, R_P10, R_T};
            5'd6:  u = '{OP_ADD, R_T, R_QA, R_T};
            5'd7:  u = '{OP_MUL, R_DT, R_T, R_T};
            5'd8:  u = '{OP_ADD, R_P00, R_T, R_P00};
            5'd9:  u = '{OP_MUL, R_DT, R_P11, R_T};   // dp
            5'd10: u = '{OP_SUB, R_P01, R_T, R_P01};
            5'd11: u = '{OP_SUB, R_P10, R_T, R_P10};
            5'd12: u = '{OP_MUL, R_QB, R_DT, R_T};
            5'd13: u = '{OP_ADD, R_P11, R_T, R_P11};
            5'd14: u = '{OP_ADD, R_P00, R_R, R_T};    // s
            5'd15: u = '{OP_DIV, R_P00, R_T, R_K0};
            5'd16: u = '{OP_DIV, R_P10, R_T, R_K1};
            5'd17: u = '{OP_SUB, R_Z, R_AN, R_Y};
            5'd18: u = '{OP_MUL, R_K0, R_Y, R_T};
            5'd19: u = '{OP_ADD, R_AN, R_T, R_AN};
            5'd20: u = '{OP_MUL, R_K1, R_Y, R_T};
            5'd21: u = '{OP_ADD, R_BI, R_T, R_BI};
            // p11 and p10 first, they need the old p01 and p00
            5'd22: u = '{OP_MUL, R_K1, R_P01, R_T};
            5'd23: u = '{OP_SUB, R_P11, R_T, R_P11};
            5'd24: u = '{OP_MUL, R_K1, R_P00, R_T};
            5'd25: u = '{OP_SUB, R_P10, R_T, R_P10};
            default: u = '{OP_ADD, R_Z, R_Z, R_Z};
        endcase
        return u;
    endfunction

    // p01 and p00 updates run after the main program
    function automatic uop_t prog_tail(input logic [4:0] i);
        uop_t u;
        u = '{OP_ADD, R_Z, R_Z, R_Z};
        case (i)
            5'd26: u = '{OP_MUL, R_K0, R_P01, R_T};
            5'd27: u = '{OP_SUB, R_P01, R_T, R_P01};
            5'd28: u = '{OP_MUL, R_K0, R_P00, R_T};
            5'd29: u = '{OP_SUB, R_P00, R_T, R_P00};
            default: u = prog(i);
        endcase
        return u;
    endfunction

    localparam logic [4:0] LAST_STEP = 5'(NSTEP + 3);

    function automatic logic signed [W-1:0] sat_s(input logic signed [W+1:0] v);
        logic signed [W-1:0] r;
        if (v > (W+2)'($signed({1'b0, {(W-1){1'b1}}})))
            r = {1'b0, {(W-1){1'b1}}};
        else if (v < -(W+2)'($signed({1'b0, {(W-1){1'b1}}})) - (W+2)'(1))
            r = {1'b1, {(W-1){1'b0}}};
        else
            r = v[W-1:0];
        return r;
    endfunction

    function automatic logic signed [W-1:0] reg_sat(input logic [22:0] v);
        logic signed [W-1:0] r;
        if (W >= 24 || v <= 23'({(W-1){1'b1}}))
            r = W'($unsigned(v));
        else
            r = {1'b0, {(W-1){1'b1}}};
        return r;
    endfunction

    function automatic logic signed [W-1:0] in_sat(input logic [31:0] v);
        logic signed [EW-1:0] e;
        logic signed [W-1:0]  r;
        e = EW'($signed(v));
        if (e > EW'($signed({1'b0, {(W-1){1'b1}}})))
            r = {1'b0, {(W-1){1'b1}}};
        else if (e < -EW'($signed({1'b0, {(W-1){1'b1}}})) - EW'(1))
            r = {1'b1, {(W-1){1'b0}}};
        else
            r = e[W-1:0];
        return r;
    endfunction

    function automatic logic [IO_WIDTH-1:0] out_sat(input logic signed [W-1:0] v);
        logic signed [EW-1:0] e;
        logic [IO_WIDTH-1:0] r;
        e = EW'(v);
        if (e > EW'(32'sh7FFFFFFF))
            r = 32'h7FFFFFFF;
        else if (e < -EW'(32'sh7FFFFFFF) - EW'(1))
            r = 32'h80000000;
        else
            r = e[IO_WIDTH-1:0];
        return r;
    endfunction

    function automatic logic [W-1:0] limit_m(input logic n);
        return n ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    endfunction

    // configuration registers
    logic [16:0] dt_reg, qa_reg, qb_reg;
    logic [22:0] r_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_reg <= 17'd655;
            qa_reg <= 17'd66;
            qb_reg <= 17'd197;
            r_reg  <= 23'd1966;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_TIME_STEP:     dt_reg <= pwdata[16:0];
                REG_ANGLE_NOISE:   qa_reg <= pwdata[16:0];
                REG_BIAS_NOISE:    qb_reg <= pwdata[16:0];
                REG_MEASURE_NOISE: r_reg  <= pwdata[22:0];
                default: ;
            endcase
        end
    end

    // register read-back
    always_comb
    begin
        unique case (paddr[3:2])
            REG_TIME_STEP:     prdata = {15'd0, dt_reg};
            REG_ANGLE_NOISE:   prdata = {15'd0, qa_reg};
            REG_BIAS_NOISE:    prdata = {15'd0, qb_reg};
            REG_MEASURE_NOISE: prdata = {9'd0, r_reg};
            default:           prdata = '0;
        endcase
    end

    // working register file
    logic signed [W-1:0] rf_reg [16];
    logic [2:0]          state_reg;
    logic [4:0]          pc_reg;
    uop_t                u;
    logic signed [W-1:0] opa, opb, res;
    logic                wb;

    // multiply path: magnitude product registered, rounding next cycle
    logic [PW-1:0]       prod_reg;
    logic                pneg_reg;
    logic [W-1:0]        ma, mb;

    // divide path: restoring, one quotient bit a cycle
    logic [DN-1:0]       dnum_reg;
    logic [W:0]          drem_reg;
    logic [W-1:0]        dden_reg;
    logic [DN-1:0]       dq_reg;
    logic                dover_reg, dneg_reg, dzero_reg;
    logic [CW-1:0]       dcnt_reg;
    logic [W:0]          rem_sh;
    logic [DN-1:0]       q_sh;
    logic [W-1:0]        limit;

    assign u   = prog_tail(pc_reg);
    assign opa = rf_reg[u.a];
    assign opb = rf_reg[u.b];
    assign ma  = opa[W-1] ? W'(-opa) : W'(opa);
    assign mb  = opb[W-1] ? W'(-opb) : W'(opb);
    assign limit = dneg_reg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    assign rem_sh = {drem_reg[W-1:0], dnum_reg[DN-1]};
    assign q_sh   = {dq_reg[DN-2:0], (rem_sh >= {1'b0, dden_reg})};

    // rounded, scaled, saturated product
    logic [PW-1:0] rnd;
    logic [PW-1:0] sc;
    logic signed [W-1:0] mul_res;
    always_comb
    begin
        rnd = prod_reg + (PW'(1) << (FRAC_BITS - 1));
        if (rnd < prod_reg)
            sc = {1'b1, {(PW-1){1'b0}}} >> (FRAC_BITS - 1);
        else
            sc = rnd >> FRAC_BITS;
        if (rnd < prod_reg || sc > PW'(limit_m(pneg_reg)))
            sc = PW'(limit_m(pneg_reg));
        mul_res = pneg_reg ? W'(-sc[W-1:0]) : W'(sc[W-1:0]);
    end

    // add / subtract and result select
    logic signed [W-1:0] div_res;
    logic [W-1:0]        dq_fin;
    always_comb
    begin
        dq_fin  = (dover_reg || dq_reg > DN'(limit)) ? limit : dq_reg[W-1:0];
        div_res = dzero_reg ? '0 : (dneg_reg ? W'(-dq_fin) : W'(dq_fin));
        wb  = 1'b0;
        res = mul_res;
        unique case (state_reg)
            ST_ISSUE:
            begin
                if (u.op == OP_ADD)
                begin
                    res = sat_s((W+2)'(opa) + (W+2)'(opb));
                    wb  = 1'b1;
                end
                else if (u.op == OP_SUB)
                begin
                    res = sat_s((W+2)'(opa) - (W+2)'(opb));
                    wb  = 1'b1;
                end
            end
            ST_MUL: wb = 1'b1;
            ST_DIV:
            begin
                res = div_res;
                wb  = (dcnt_reg == '0);
            end
            default: ;
        endcase
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = {out_sat(rf_reg[R_BI]), out_sat(rf_reg[R_AN])};

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
            dcnt_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                    if (s_axis_tvalid)
                    begin
                        state_reg <= ST_ISSUE;
                        pc_reg    <= '0;
                    end
                ST_ISSUE:
                begin
                    if (u.op == OP_MUL)
                        state_reg <= ST_MUL;
                    else if (u.op == OP_DIV)
                    begin
                        state_reg <= ST_DIV;
                        dcnt_reg  <= CW'(DN);
                    end
                    else if (pc_reg == LAST_STEP)
                        state_reg <= ST_OUT;
                    else
                        pc_reg <= pc_reg + 5'd1;
                end
                ST_MUL:
                    if (pc_reg == LAST_STEP)
                        state_reg <= ST_OUT;
                    else
                    begin
                        state_reg <= ST_ISSUE;
                        pc_reg    <= pc_reg + 5'd1;
                    end
                ST_DIV:
                    if (dcnt_reg == '0)
                    begin
                        state_reg <= ST_ISSUE;
                        pc_reg    <= pc_reg + 5'd1;
                    end
                    else
                        dcnt_reg <= dcnt_reg - CW'(1);
                ST_OUT:
                    if (m_axis_tready)
                        state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
                rf_reg[i] <= '0;
        end
        else
        begin
            if (state_reg == ST_IDLE && s_axis_tvalid)
            begin
                rf_reg[R_DT] <= reg_sat({6'd0, dt_reg});
                rf_reg[R_QA] <= reg_sat({6'd0, qa_reg});
                rf_reg[R_QB] <= reg_sat({6'd0, qb_reg});
                rf_reg[R_R]  <= reg_sat(r_reg);
                rf_reg[R_Z]  <= in_sat(s_axis_tdata[31:0]);
                rf_reg[R_RT] <= in_sat(s_axis_tdata[63:32]);
            end
            else if (wb)
                rf_reg[u.d] <= res;
        end
    end

    // multiplier and divider working registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ISSUE && u.op == OP_MUL)
        begin
            prod_reg <= PW'(ma) * PW'(mb);
            pneg_reg <= opa[W-1] ^ opb[W-1];
        end
        if (state_reg == ST_ISSUE && u.op == OP_DIV)
        begin
            dnum_reg  <= {ma, {FRAC_BITS{1'b0}}};
            dden_reg  <= mb;
            drem_reg  <= '0;
            dq_reg    <= '0;
            dover_reg <= 1'b0;
            dneg_reg  <= opa[W-1] ^ opb[W-1];
            dzero_reg <= (opb == '0);
        end
        else if (state_reg == ST_DIV && dcnt_reg != '0)
        begin
            dnum_reg <= dnum_reg << 1;
            dq_reg   <= q_sh;
            drem_reg <= q_sh[0] ? rem_sh - {1'b0, dden_reg} : rem_sh;
            if (q_sh > DN'(limit))
                dover_reg <= 1'b1;
        end
    end
endmodule
`default_nettype wire
